[src/utf8_stream_decoder_unit_assert.svh]
// ----------------------------------------------------------------------------
// UTF-8 stream decoder assertion macros
// Shared concurrent assertion helpers, clocked on clock, off during reset.
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_DECODER_UNIT_ASSERT_SVH
`define UTF8_STREAM_DECODER_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define USD_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define USD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/usd_pkg.sv]
// ----------------------------------------------------------------------------
// UTF-8 stream decoder package
// Shared types and constants for the decoder datapath.
// ----------------------------------------------------------------------------
package usd_pkg;

   localparam int unsigned CP_W = 21;

   localparam logic [1:0] ST_CODE_POINT = 2'd0;
   localparam logic [1:0] ST_MISSING    = 2'd1;
   localparam logic [1:0] ST_STRAY      = 2'd2;
   localparam logic [1:0] ST_BOM        = 2'd3;

   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_EOF  = 1'b1;

   localparam logic [CP_W-1:0] BOM_VALUE = 21'h00FEFF;

   typedef logic [1:0]      status_type;
   typedef logic [CP_W-1:0] code_point_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
   } item_type;

   typedef struct packed {
      logic           emit;
      code_point_type code_point;
      status_type     status;
   } result_type;

endpackage

[src/usd_if.sv]
// ----------------------------------------------------------------------------
// UTF-8 stream decoder channels
// Valid/ready channels for input bytes and decoded results.
// ----------------------------------------------------------------------------
interface usd_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] data_byte;

   modport source (output valid, output kind, output data_byte, input ready);
   modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

interface usd_rsp_if;
   logic        valid;
   logic        ready;
   logic [20:0] code_point;
   logic [1:0]  status;

   modport source (output valid, output code_point, output status, input ready);
   modport sink   (input valid, input code_point, input status, output ready);
endinterface

[src/usd_in_stage.sv]
// ----------------------------------------------------------------------------
// UTF-8 stream decoder input register
// Holds one accepted transaction until the decode stage consumes it.
// ----------------------------------------------------------------------------
module usd_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  usd_pkg::item_type in_item,
   input  logic              advance,
   output logic              item_valid,
   output usd_pkg::item_type item
);
   import usd_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;

   assign in_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (in_ready) begin
         valid_in = in_valid;
         item_in  = in_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

[src/usd_decode.sv]
// ----------------------------------------------------------------------------
// UTF-8 stream decoder core
// Sequence state and the per-byte decode; state commits when the item advances.
// ----------------------------------------------------------------------------
`include "utf8_stream_decoder_unit_assert.svh"

module usd_decode (
   input  logic                clock,
   input  logic                reset,
   input  logic                item_valid,
   input  usd_pkg::item_type   item,
   input  logic                advance,
   output usd_pkg::result_type result
);
   import usd_pkg::*;

   code_point_type partial_ff, partial_in;
   logic [1:0]     due_ff, due_in;
   logic           text_ff, text_in;
   logic           halted_ff, halted_in;
   code_point_type shifted;

   assign shifted = {partial_ff[CP_W-7:0], item.data_byte[5:0]};

   always_comb begin
      partial_in        = partial_ff;
      due_in            = due_ff;
      text_in           = text_ff;
      result.emit       = 1'b0;
      result.code_point = '0;
      result.status     = ST_CODE_POINT;
      priority if (!item_valid || halted_ff) begin
         // nothing to do
      end else if (item.kind == KIND_EOF) begin
         if (due_ff != 2'd0) begin
            result.emit   = 1'b1;
            result.status = ST_MISSING;
         end
      end else if (!item.data_byte[7]) begin
         if (due_ff != 2'd0) begin
            result.emit   = 1'b1;
            result.status = ST_MISSING;
         end else if (item.data_byte != 8'h00) begin
            text_in           = 1'b1;
            result.emit       = 1'b1;
            result.code_point = {{(CP_W-8){1'b0}}, item.data_byte};
         end
      end else if (item.data_byte[7:6] == 2'b10) begin
         if (due_ff == 2'd0) begin
            result.emit   = 1'b1;
            result.status = ST_STRAY;
         end else begin
            due_in     = due_ff - 2'd1;
            partial_in = shifted;
            if (due_ff == 2'd1) begin
               if (shifted == BOM_VALUE) begin
                  // leading BOM is swallowed, a later one is an error
                  if (text_ff) begin
                     result.emit   = 1'b1;
                     result.status = ST_BOM;
                  end
               end else begin
                  text_in           = 1'b1;
                  result.emit       = 1'b1;
                  result.code_point = shifted;
               end
            end
         end
      end else if (item.data_byte[7:5] == 3'b110) begin
         due_in     = 2'd1;
         partial_in = {{(CP_W-5){1'b0}}, item.data_byte[4:0]};
      end else if (item.data_byte[7:4] == 4'b1110) begin
         due_in     = 2'd2;
         partial_in = {{(CP_W-4){1'b0}}, item.data_byte[3:0]};
      end else if (item.data_byte[7:3] == 5'b11110) begin
         due_in     = 2'd3;
         partial_in = {{(CP_W-3){1'b0}}, item.data_byte[2:0]};
      end else begin
         // F8-FF dropped, pending sequence kept
      end
   end

   assign halted_in = halted_ff || (result.emit && (result.status != ST_CODE_POINT));

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
         due_ff     <= 2'd0;
         text_ff    <= 1'b0;
         halted_ff  <= 1'b0;
      end else if (advance) begin
         partial_ff <= partial_in;
         due_ff     <= due_in;
         text_ff    <= text_in;
         halted_ff  <= halted_in;
      end
   end

   `USD_ASSERT_NEXT(a_halt_sticky, halted_ff, halted_ff, "halt flag cleared without reset")
   `USD_ASSERT_SAME(a_halt_silent, halted_ff, !result.emit, "result produced while halted")
   `USD_ASSERT_NEXT(a_error_halts, advance && result.emit && (result.status != ST_CODE_POINT),
      halted_ff, "error transaction did not halt the decoder")
   `USD_ASSERT_SAME(a_bom_needs_text, result.emit && (result.status == ST_BOM), text_ff,
      "misplaced BOM reported before any text")

endmodule

[src/usd_out_stage.sv]
// ----------------------------------------------------------------------------
// UTF-8 stream decoder output register
// Holds one result transaction until the consumer takes it.
// ----------------------------------------------------------------------------
module usd_out_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  usd_pkg::result_type result,
   output logic                free,
   output logic                out_valid,
   input  logic                out_ready,
   output usd_pkg::code_point_type out_code_point,
   output usd_pkg::status_type out_status
);
   import usd_pkg::*;

   logic           valid_ff, valid_in;
   code_point_type cp_ff, cp_in;
   status_type     status_ff, status_in;

   assign free = !valid_ff || out_ready;

   always_comb begin
      valid_in  = valid_ff && !out_ready;
      cp_in     = cp_ff;
      status_in = status_ff;
      if (load) begin
         valid_in  = 1'b1;
         cp_in     = result.code_point;
         status_in = result.status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      cp_ff     <= cp_in;
      status_ff <= status_in;
   end

   assign out_valid      = valid_ff;
   assign out_code_point = cp_ff;
   assign out_status     = status_ff;

endmodule

[src/utf8_stream_decoder_unit.sv]
// Path: a byte accepted into the input register is decoded combinationally, and
// its result is loaded into the result register, which drives rsp, as it advances.
// Throughput: one byte per cycle; the decode is a single pass between the input
// register and the result register. Input stalls only while a byte that has a
// result waits on a full result register that is not read in that cycle.
// Reset (synchronous, active high) empties both registers and clears the
// sequence state, text flag and halt flag.
// ----------------------------------------------------------------------------
// UTF-8 stream decoder unit
// Decodes a byte stream with end-of-file marks into code points or an error.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_unit (
   input  logic clock,
   input  logic reset,
   usd_req_if.sink   req_ch,
   usd_rsp_if.source rsp_ch
);
   import usd_pkg::*;

   item_type   req_item;
   item_type   item;
   logic       item_valid;
   logic       advance;
   logic       out_free;
   result_type result;

   assign req_item = {req_ch.kind, req_ch.data_byte};

   // an item with no result never waits on the output side
   assign advance = item_valid && (!result.emit || out_free);

   usd_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_ch.valid),
      .in_ready   (req_ch.ready),
      .in_item    (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   usd_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .advance    (advance),
      .result     (result)
   );

   usd_out_stage u_out (
      .clock          (clock),
      .reset          (reset),
      .load           (advance && result.emit),
      .result         (result),
      .free           (out_free),
      .out_valid      (rsp_ch.valid),
      .out_ready      (rsp_ch.ready),
      .out_code_point (rsp_ch.code_point),
      .out_status     (rsp_ch.status)
   );

endmodule
